@@ hdl/msbb_pkg.sv @@
// ----------------------------------------------------------------------------
// msbb_pkg: shared types and constants of the bang-bang speed controller
// Commands, relay sequence phases, register indexes, reset values and the
// structs passed between the configuration, core and top-level modules.
// ----------------------------------------------------------------------------
package msbb_pkg;

  // widths
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // event codes carried by an input item
  typedef enum logic [1:0] {
    CMD_CAPTURE   = 2'd0,
    CMD_B_EDGE    = 2'd1,
    CMD_SLOW_TICK = 2'd2,
    CMD_CTRL_TICK = 2'd3
  } cmd_e;

  // relay change sequence phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRE  = 2'd1,
    PH_POST = 2'd2
  } phase_e;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_PERIOD = 3'd0,
    CFG_MIN_PERIOD    = 3'd1,
    CFG_WANTED_DIR    = 3'd2,
    CFG_STALL_LIMIT   = 3'd3,
    CFG_RELAY_DELAY   = 3'd4
  } cfg_idx_e;

  // reset values
  localparam logic [PeriodW-1:0] StoppedPeriod   = 16'hFFFF;
  localparam logic [PeriodW-1:0] RstMinPeriod    = 16'd21000;
  localparam logic [PeriodW-1:0] RstTargetPeriod = 16'd0;
  localparam logic [CountW-1:0]  RstStallLimit   = 8'd38;
  localparam logic [CountW-1:0]  RstRelayDelay   = 8'd5;

  // relay patterns, bit 1 relay_one, bit 0 relay_two
  localparam logic [1:0] RelaysCcw = 2'b10;
  localparam logic [1:0] RelaysCw  = 2'b01;

  // configuration register set
  typedef struct packed {
    logic [PeriodW-1:0] target_speed_period;
    logic [PeriodW-1:0] min_allowed_period;
    logic               wanted_direction;
    logic [CountW-1:0]  stall_tick_limit;
    logic [CountW-1:0]  relay_delay_ticks;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic               drive_on;
    logic               relay_one;
    logic               relay_two;
    logic [PeriodW-1:0] measured_period;
    logic               measured_direction;
    logic               switching;
  } result_t;

endpackage

@@ hdl/msbb_if.sv @@
// ----------------------------------------------------------------------------
// msbb_in_if / msbb_out_if: item channels of the speed controller
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// event channel
interface msbb_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic [msbb_pkg::PeriodW-1:0]    capture_time;

  modport source (output valid, output command, output capture_time, input ready);
  modport sink   (input valid, input command, input capture_time, output ready);
endinterface

// result channel
interface msbb_out_if;
  logic                            valid;
  logic                            ready;
  logic                            drive_on;
  logic                            relay_one;
  logic                            relay_two;
  logic [msbb_pkg::PeriodW-1:0]    measured_period;
  logic                            measured_direction;
  logic                            switching;

  modport source (output valid, output drive_on, output relay_one, output relay_two,
                  output measured_period, output measured_direction, output switching,
                  input ready);
  modport sink   (input valid, input drive_on, input relay_one, input relay_two,
                  input measured_period, input measured_direction, input switching,
                  output ready);
endinterface

@@ hdl/motor_speed_bang_bang_controller_unit.sv @@
// ----------------------------------------------------------------------------
// motor_speed_bang_bang_controller_unit: bang-bang motor speed controller
// Encoder period capture, stall detection, direction relay sequencing and
// on/off drive law, one event item per clock while out_o takes results.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries event items (command, capture_time); out_o returns one
//   result item per event, showing the controller state after that event.
//   The cfg write port sets the five control registers; write them only
//   while no item is in flight.
// Flow: an item accepted into the input register is applied to the state
//   when the result register is free; its result is then held in the result
//   register and is valid on out_o from then on.
// Throughput: one item per cycle while out_o takes results; the state update
//   is a single pass of subtract/compare logic between the input and result registers.
// Stall: when out_o is not taken, the result register holds, the input
//   register keeps at most one more item, and in_i.ready then drops.
// Reset: asynchronous, active low; control registers take their defaults,
//   the period reads as stopped (65535), relays open, drive off.
// ----------------------------------------------------------------------------
module motor_speed_bang_bang_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msbb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [msbb_pkg::CfgDatW-1:0]    cfg_data_i,
  msbb_in_if.sink                         in_i,
  msbb_out_if.source                      out_o
);

  msbb_pkg::cfg_t               cfg;
  msbb_pkg::result_t            result;

  logic                         in_valid_q, in_valid_d;
  logic [1:0]                   in_cmd_q;
  logic [msbb_pkg::PeriodW-1:0] in_cap_q;
  logic                         out_valid_q, out_valid_d;
  msbb_pkg::result_t            out_res_q;
  logic                         advance;
  logic                         fire;
  logic                         in_take;

  // configuration registers
  msbb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake: result register frees, input register moves on
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = fire || (out_valid_q && !out_o.ready);

  // state update
  msbb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .command_i (in_cmd_q),
    .capture_i (in_cap_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= in_i.command;
      in_cap_q <= in_i.capture_time;
    end
  end

  // result item register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= result;
    end
  end

  // result channel
  assign out_o.valid              = out_valid_q;
  assign out_o.drive_on           = out_res_q.drive_on;
  assign out_o.relay_one          = out_res_q.relay_one;
  assign out_o.relay_two          = out_res_q.relay_two;
  assign out_o.measured_period    = out_res_q.measured_period;
  assign out_o.measured_direction = out_res_q.measured_direction;
  assign out_o.switching          = out_res_q.switching;

  // a stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_res_q)))
    else $error("stalled result lost");

  // a held input item is not overwritten by a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !in_i.ready)
    else $error("input register overrun");

  // every applied item leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result missing after update");

endmodule

@@ hdl/msbb_cfg.sv @@
// ----------------------------------------------------------------------------
// msbb_cfg: configuration register file
// Decodes the write port into the five control registers; unknown indexes
// are dropped and data is truncated to each register's width.
// ----------------------------------------------------------------------------
module msbb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msbb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [msbb_pkg::CfgDatW-1:0]    cfg_data_i,
  output msbb_pkg::cfg_t                  cfg_o
);

  msbb_pkg::cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (msbb_pkg::cfg_idx_e'(cfg_idx_i))
        msbb_pkg::CFG_TARGET_PERIOD: cfg_d.target_speed_period = cfg_data_i;
        msbb_pkg::CFG_MIN_PERIOD:    cfg_d.min_allowed_period  = cfg_data_i;
        msbb_pkg::CFG_WANTED_DIR:    cfg_d.wanted_direction    = cfg_data_i[0];
        msbb_pkg::CFG_STALL_LIMIT:   cfg_d.stall_tick_limit    = cfg_data_i[7:0];
        msbb_pkg::CFG_RELAY_DELAY:   cfg_d.relay_delay_ticks   = cfg_data_i[7:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_speed_period <= msbb_pkg::RstTargetPeriod;
      cfg_q.min_allowed_period  <= msbb_pkg::RstMinPeriod;
      cfg_q.wanted_direction    <= 1'b0;
      cfg_q.stall_tick_limit    <= msbb_pkg::RstStallLimit;
      cfg_q.relay_delay_ticks   <= msbb_pkg::RstRelayDelay;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/msbb_core.sv @@
// ----------------------------------------------------------------------------
// msbb_core: controller state and per-event update
// Holds the encoder, stall and relay sequence state and applies one event
// per cycle when fire_i is high; the result is the state as it stands after the event.
// ----------------------------------------------------------------------------
module msbb_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [1:0]                      command_i,
  input  logic [msbb_pkg::PeriodW-1:0]    capture_i,
  input  msbb_pkg::cfg_t                  cfg_i,
  output msbb_pkg::result_t               result_o
);

  logic [msbb_pkg::PeriodW-1:0] last_q, last_d;
  logic [msbb_pkg::PeriodW-1:0] period_q, period_d;
  logic [msbb_pkg::CountW-1:0]  stall_q, stall_d;
  logic                         b_q, b_d;
  logic                         dir_q, dir_d;
  logic [1:0]                   relay_q, relay_d;
  logic                         drive_q, drive_d;
  msbb_pkg::phase_e             phase_q, phase_d;
  logic [msbb_pkg::CountW-1:0]  delay_q, delay_d;

  logic                         ctrl_tick;
  logic [1:0]                   want_relays;
  logic [msbb_pkg::PeriodW-1:0] limit;
  logic [msbb_pkg::CountW-1:0]  stall_inc;
  logic                         delay_done;

  // shared decode terms
  assign ctrl_tick   = fire_i && (msbb_pkg::cmd_e'(command_i) == msbb_pkg::CMD_CTRL_TICK);
  assign want_relays = cfg_i.wanted_direction ? msbb_pkg::RelaysCcw : msbb_pkg::RelaysCw;
  assign limit       = (cfg_i.target_speed_period < cfg_i.min_allowed_period) ?
                       cfg_i.min_allowed_period : cfg_i.target_speed_period;
  assign stall_inc   = stall_q + 8'd1;
  assign delay_done  = (delay_q == '0);

  // relay sequence next state
  always_comb begin
    phase_d = phase_q;
    if (ctrl_tick) begin
      unique case (phase_q)
        msbb_pkg::PH_IDLE: if (relay_q != want_relays) phase_d = msbb_pkg::PH_PRE;
        msbb_pkg::PH_PRE:  if (delay_done) phase_d = msbb_pkg::PH_POST;
        msbb_pkg::PH_POST: if (delay_done) phase_d = msbb_pkg::PH_IDLE;
        default:           phase_d = msbb_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath update per event
  always_comb begin
    last_d   = last_q;
    period_d = period_q;
    stall_d  = stall_q;
    b_d      = b_q;
    dir_d    = dir_q;
    relay_d  = relay_q;
    drive_d  = drive_q;
    delay_d  = delay_q;
    if (fire_i) begin
      case (msbb_pkg::cmd_e'(command_i))
        msbb_pkg::CMD_CAPTURE: begin
          period_d = capture_i - last_q;
          last_d   = capture_i;
          stall_d  = '0;
          dir_d    = b_q;
        end
        msbb_pkg::CMD_B_EDGE: begin
          b_d = ~b_q;
        end
        msbb_pkg::CMD_SLOW_TICK: begin
          stall_d = stall_inc;
          if (stall_inc >= cfg_i.stall_tick_limit) begin
            period_d = msbb_pkg::StoppedPeriod;
            stall_d  = '0;
          end
        end
        default: begin
          if (phase_q == msbb_pkg::PH_IDLE) begin
            if (relay_q != want_relays) begin
              drive_d = 1'b0;
              delay_d = cfg_i.relay_delay_ticks;
            end else begin
              drive_d = (period_q >= limit);
            end
          end else begin
            drive_d = 1'b0;
            if (!delay_done) begin
              delay_d = delay_q - 8'd1;
            end else if (phase_q == msbb_pkg::PH_PRE) begin
              relay_d = want_relays;
              delay_d = cfg_i.relay_delay_ticks;
            end
          end
        end
      endcase
    end
  end

  // result view of the updated state
  always_comb begin
    result_o.drive_on           = drive_d;
    result_o.relay_one          = relay_d[1];
    result_o.relay_two          = relay_d[0];
    result_o.measured_period    = period_d;
    result_o.measured_direction = dir_d;
    result_o.switching          = (phase_d != msbb_pkg::PH_IDLE);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      period_q <= msbb_pkg::StoppedPeriod;
      stall_q  <= '0;
      b_q      <= 1'b0;
      dir_q    <= 1'b0;
      relay_q  <= 2'b00;
      drive_q  <= 1'b0;
      phase_q  <= msbb_pkg::PH_IDLE;
      delay_q  <= '0;
    end else begin
      last_q   <= last_d;
      period_q <= period_d;
      stall_q  <= stall_d;
      b_q      <= b_d;
      dir_q    <= dir_d;
      relay_q  <= relay_d;
      drive_q  <= drive_d;
      phase_q  <= phase_d;
      delay_q  <= delay_d;
    end
  end

  // drive stays off for the whole relay sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != msbb_pkg::PH_IDLE) |-> !drive_q)
    else $error("drive on during relay change");

  // both relays are never closed together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q != 2'b11)
    else $error("both relays closed");

  // a capture restarts the stall count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (msbb_pkg::cmd_e'(command_i) == msbb_pkg::CMD_CAPTURE)) |=> (stall_q == '0))
    else $error("stall count not cleared by capture");

  // relays only change at the end of the first delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (relay_q != $past(relay_q)) |-> (phase_q == msbb_pkg::PH_POST))
    else $error("relay change outside sequence");

endmodule
